>>> src/piwe_pkg.sv
// Package for the parallel I2C write engine: input kind codes, queue entry
// type, lane constants and shared widths. No dependencies.
package piwe_pkg;

  localparam int unsigned Lanes      = 3;
  localparam int unsigned InputLanes = 3;
  localparam int unsigned LaneCount  = (Lanes < InputLanes) ? Lanes : InputLanes;

  localparam logic [2:0] ReleasedAll = 3'h7;
  localparam logic [2:0] LaneMask    = 3'((1 << LaneCount) - 1) & ReleasedAll;

  localparam logic [1:0] KindStart = 2'd0;
  localparam logic [1:0] KindStop  = 2'd1;
  localparam logic [1:0] KindWrite = 2'd2;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OpStart,
    OpStop,
    OpByte
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic [InputLanes-1:0][7:0]  lane_bytes;
  } entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

endpackage

>>> src/parallel_i2c_write_engine.sv
// Top level of the parallel I2C write engine: front end, queue and line
// sequencer. Depends on piwe_pkg, piwe_front, piwe_queue and piwe_back.
//
//   Channel | Direction | Handshake              | Payload
//   input   | in        | in_valid_i / in_stall_o | kind_i, lane0..2_byte_i
//   output  | out       | out_valid_o / out_stall_i | data_lines_o, clock_line_o, last_o
//
// One result leaves per cycle while the output is not stalled; a start item
// gives 4 results, a stop item 3 and a write item 27, set by the sequencer's
// step counters. A two-entry queue lets new items be accepted while an
// operation is still being clocked out. Items of unused kind are accepted and
// give no result. Reset leaves all driven lanes high and the clock low.
module parallel_i2c_write_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] lane0_byte_i,
  input  logic [7:0] lane1_byte_i,
  input  logic [7:0] lane2_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] data_lines_o,
  output logic       clock_line_o,
  output logic       last_o
);
  import piwe_pkg::*;

  q_status_t q_status;
  entry_t    push_entry;
  entry_t    head;
  logic      push;
  logic      pop;

  piwe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .lane0_byte_i (lane0_byte_i),
    .lane1_byte_i (lane1_byte_i),
    .lane2_byte_i (lane2_byte_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  piwe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  piwe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_lines_o (data_lines_o),
    .clock_line_o (clock_line_o),
    .last_o       (last_o)
  );

endmodule

>>> src/piwe_front.sv
// Front end of the write engine: accepts items, sorts them by kind and
// drops unused kinds. Depends on piwe_pkg.
module piwe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          lane0_byte_i,
  input  logic [7:0]          lane1_byte_i,
  input  logic [7:0]          lane2_byte_i,
  input  piwe_pkg::q_status_t q_status_i,
  output logic                push_o,
  output piwe_pkg::entry_t    push_entry_o
);
  import piwe_pkg::*;

  logic known;
  logic accept;

  always_comb begin
    known                   = 1'b1;
    push_entry_o.op         = OpStart;
    push_entry_o.lane_bytes = {lane2_byte_i, lane1_byte_i, lane0_byte_i};
    unique case (kind_i)
      KindStart: push_entry_o.op = OpStart;
      KindStop:  push_entry_o.op = OpStop;
      KindWrite: push_entry_o.op = OpByte;
      default:   known = 1'b0;
    endcase
  end

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = accept && known;

  // An unused kind never reaches the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && kind_i != KindStart && kind_i != KindStop && kind_i != KindWrite)
    |-> !push_o)
    else $error("unused kind pushed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_status_i.full)
    else $error("push into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i == KindWrite) |-> push_entry_o.op == OpByte)
    else $error("write item misclassified");

endmodule

>>> src/piwe_queue.sv
// Two-entry queue between the front end and the line sequencer.
// Depends on piwe_pkg.
module piwe_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  piwe_pkg::entry_t    push_entry_i,
  input  logic                pop_i,
  output piwe_pkg::entry_t    head_o,
  output piwe_pkg::q_status_t status_o
);
  import piwe_pkg::*;

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign status_o.full  = (count_q == QCntW'(QDepth));
  assign status_o.valid = (count_q != '0);
  assign head_o         = mem_q[rd_ptr_q];

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> status_o.valid)
    else $error("pop from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && !status_o.full) |=> status_o.valid)
    else $error("queue lost an item");

endmodule

>>> src/piwe_back.sv
// Line sequencer of the write engine: steps through the line changes of one
// operation per queue entry and holds the bus levels as the result register.
// Depends on piwe_pkg.
module piwe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  piwe_pkg::entry_t    head_i,
  input  piwe_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          data_lines_o,
  output logic                clock_line_o,
  output logic                last_o
);
  import piwe_pkg::*;

  logic                        busy_q, busy_d;
  op_e                         op_q;
  logic [InputLanes-1:0][7:0]  bytes_q;
  logic [1:0]                  phase_q, phase_d;
  logic [3:0]                  bit_q, bit_d;
  logic [2:0]                  data_q, data_d;
  logic                        clock_q, clock_d;
  logic                        last_q, last_now;
  logic                        out_valid_q, out_valid_d;
  logic                        advance;
  logic [2:0]                  bit_idx;
  logic [2:0]                  lane_bits;

  assign advance = busy_q && (!out_valid_q || !out_stall_i);
  assign bit_idx = ~bit_q[2:0];

  always_comb begin
    lane_bits = '0;
    for (int ch = 0; ch < int'(LaneCount); ch++) begin
      lane_bits[ch] = bytes_q[ch][bit_idx];
    end
  end

  always_comb begin
    data_d   = data_q;
    clock_d  = clock_q;
    last_now = 1'b0;
    phase_d  = phase_q + 1'b1;
    bit_d    = bit_q;
    unique case (op_q)
      OpStart: begin
        unique case (phase_q)
          2'd0:    data_d  = ReleasedAll & LaneMask;
          2'd1:    clock_d = 1'b1;
          2'd2:    data_d  = '0;
          default: begin
            clock_d  = 1'b0;
            last_now = 1'b1;
          end
        endcase
      end
      OpStop: begin
        unique case (phase_q)
          2'd0:    data_d  = '0;
          2'd1:    clock_d = 1'b1;
          default: begin
            data_d   = ReleasedAll & LaneMask;
            last_now = 1'b1;
          end
        endcase
      end
      default: begin
        unique case (phase_q)
          2'd0:    data_d  = (bit_q[3] ? ReleasedAll : lane_bits) & LaneMask;
          2'd1:    clock_d = 1'b1;
          default: begin
            clock_d  = 1'b0;
            phase_d  = '0;
            bit_d    = bit_q + 1'b1;
            last_now = bit_q[3];
          end
        endcase
      end
    endcase
  end

  assign pop_o = q_status_i.valid && (!busy_q || (advance && last_now));

  always_comb begin
    busy_d = busy_q;
    if (pop_o) begin
      busy_d = 1'b1;
    end else if (advance && last_now) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      data_q      <= ReleasedAll & LaneMask;
      clock_q     <= 1'b0;
      last_q      <= 1'b0;
      phase_q     <= '0;
      bit_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        data_q  <= data_d;
        clock_q <= clock_d;
        last_q  <= last_now;
      end
      if (pop_o) begin
        phase_q <= '0;
        bit_q   <= '0;
      end else if (advance) begin
        phase_q <= phase_d;
        bit_q   <= bit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q    <= head_i.op;
      bytes_q <= head_i.lane_bytes;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_lines_o = data_q;
  assign clock_line_o = clock_q;
  assign last_o       = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_q & ~LaneMask) == '0)
    else $error("undriven lane set high");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (bit_q <= 4'd8))
    else $error("bit counter overran");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_now && !pop_o) |=> !busy_q)
    else $error("sequencer kept running after the final line state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_now && op_q == OpByte) |-> !clock_d)
    else $error("byte operation ended with the clock high");

endmodule

>>> sim/line_state_checker.sv
`timescale 1ns / 100ps
// Checker for the parallel I2C write engine: watches both channels, works out the
// line states each accepted item should produce and compares every result in order.
// Depends on piwe_pkg for the kind codes and the lane constants.
module line_state_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] kind_i,
  input  logic [7:0] lane0_byte_i,
  input  logic [7:0] lane1_byte_i,
  input  logic [7:0] lane2_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] data_lines_i,
  input  logic       clock_line_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         items_o,
  output int         results_o
);
  import piwe_pkg::*;

  typedef struct packed {
    logic [2:0] data_lines;
    logic       clock_line;
    logic       last;
  } line_state_t;

  line_state_t line_states_q[$];
  logic [2:0]  data_level;
  logic        clock_level;

  task automatic push_state(input logic fin);
    line_state_t s;
    s.data_lines = data_level;
    s.clock_line = clock_level;
    s.last       = fin;
    line_states_q.push_back(s);
  endtask

  task automatic drive_data(input logic [2:0] v, input logic fin);
    data_level = v & LaneMask;
    push_state(fin);
  endtask

  task automatic drive_clock(input logic v, input logic fin);
    clock_level = v;
    push_state(fin);
  endtask

  task automatic expand_operation(input logic [1:0] kind, input logic [7:0] b0,
                                  input logic [7:0] b1, input logic [7:0] b2);
    logic [2:0] lines;
    case (kind)
      KindStart: begin
        drive_data(ReleasedAll, 1'b0);
        drive_clock(1'b1, 1'b0);
        drive_data(3'b000, 1'b0);
        drive_clock(1'b0, 1'b1);
      end
      KindStop: begin
        drive_data(3'b000, 1'b0);
        drive_clock(1'b1, 1'b0);
        drive_data(ReleasedAll, 1'b1);
      end
      KindWrite: begin
        for (int bit_idx = 7; bit_idx >= 0; bit_idx--) begin
          lines = {b2[bit_idx], b1[bit_idx], b0[bit_idx]};
          drive_data(lines, 1'b0);
          drive_clock(1'b1, 1'b0);
          drive_clock(1'b0, 1'b0);
        end
        drive_data(ReleasedAll, 1'b0);
        drive_clock(1'b1, 1'b0);
        drive_clock(1'b0, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_state_t exp_state;
    if (!rst_ni) begin
      data_level   = ReleasedAll & LaneMask;
      clock_level  = 1'b0;
      line_states_q.delete();
      fail_count_o = 0;
      items_o      = 0;
      results_o    = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        expand_operation(kind_i, lane0_byte_i, lane1_byte_i, lane2_byte_i);
        items_o++;
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (line_states_q.size() == 0) begin
          $error("unexpected result: data_lines %0h clock_line %0b last %0b",
                 data_lines_i, clock_line_i, last_i);
          fail_count_o++;
        end else begin
          exp_state = line_states_q.pop_front();
          if (data_lines_i !== exp_state.data_lines) begin
            $error("data_lines: expected %0h, actual %0h", exp_state.data_lines, data_lines_i);
            fail_count_o++;
          end
          if (clock_line_i !== exp_state.clock_line) begin
            $error("clock_line: expected %0b, actual %0b", exp_state.clock_line, clock_line_i);
            fail_count_o++;
          end
          if (last_i !== exp_state.last) begin
            $error("last: expected %0b, actual %0b", exp_state.last, last_i);
            fail_count_o++;
          end
        end
      end
      pending_o = line_states_q.size();
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Testbench top for the parallel I2C write engine: clock, reset, item stimulus and
// random output stalls. Depends on piwe_pkg, the engine and line_state_checker.
module tb;
  import piwe_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int         CycleLimit = 200000;
  localparam int         HoldCycles = 250;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] kind;
  logic [7:0] lane0_byte;
  logic [7:0] lane1_byte;
  logic [7:0] lane2_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] data_lines;
  logic       clock_line;
  logic       last;

  int fail_count;
  int pending;
  int items_seen;
  int results_seen;
  int cycles;
  int sent;
  bit idle_on;
  bit hold_done;

  parallel_i2c_write_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .kind_i      (kind),
    .lane0_byte_i(lane0_byte),
    .lane1_byte_i(lane1_byte),
    .lane2_byte_i(lane2_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .data_lines_o(data_lines),
    .clock_line_o(clock_line),
    .last_o      (last)
  );

  line_state_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .kind_i      (kind),
    .lane0_byte_i(lane0_byte),
    .lane1_byte_i(lane1_byte),
    .lane2_byte_i(lane2_byte),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .data_lines_i(data_lines),
    .clock_line_i(clock_line),
    .last_i      (last),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .items_o     (items_seen),
    .results_o   (results_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [7:0] b0,
                           input logic [7:0] b1, input logic [7:0] b2);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
    end
    @(negedge clk_i);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    lane0_byte <= b0;
    lane1_byte <= b1;
    lane2_byte <= b2;
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic send_random_write();
    send_item(KindWrite, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin : receiver
    int burst;
    out_stall = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && items_seen >= 30) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 3);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int n_bytes;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    kind       = KindStart;
    lane0_byte = 8'h00;
    lane1_byte = 8'h00;
    lane2_byte = 8'h00;
    idle_on    = 1'b1;
    sent       = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: extremes of the lane bytes, every kind, the unused kind,
    // and operations that follow a stop, when the clock is left high.
    send_item(KindStart, 8'hFF, 8'hFF, 8'hFF);
    send_item(KindWrite, 8'h00, 8'h00, 8'h00);
    send_item(KindWrite, 8'hFF, 8'hFF, 8'hFF);
    send_item(KindWrite, 8'hAA, 8'h55, 8'h0F);
    send_item(KindStop, 8'h00, 8'h00, 8'h00);
    send_item(KindStop, 8'hA5, 8'h5A, 8'hFF);
    send_item(KindStart, 8'h00, 8'h00, 8'h00);
    send_item(KindWrite, 8'hF0, 8'h0F, 8'h81);
    send_item(KindUnused, 8'h00, 8'h00, 8'h00);
    send_item(KindStart, 8'h12, 8'h34, 8'h56);
    send_item(KindStart, 8'h00, 8'h00, 8'h00);
    send_item(KindWrite, 8'h01, 8'h80, 8'h7E);
    send_item(KindUnused, 8'hFF, 8'hFF, 8'hFF);
    send_item(KindStop, 8'h00, 8'h00, 8'h00);
    send_item(KindWrite, 8'h5A, 8'hA5, 8'hC3);
    send_item(KindUnused, 8'h3C, 8'hC3, 8'h99);
    send_item(KindStart, 8'h00, 8'h00, 8'h00);
    send_item(KindWrite, 8'h80, 8'h01, 8'hFF);
    send_item(KindStop, 8'hFF, 8'h00, 8'hFF);

    // Random part: mostly framed transfers, with some stray items of any kind.
    while (sent < 118) begin
      if (sent >= 98) begin
        idle_on = 1'b0;
      end
      if ($urandom_range(0, 9) < 8) begin
        send_item(KindStart, 8'($urandom), 8'($urandom), 8'($urandom));
        n_bytes = $urandom_range(1, 4);
        repeat (n_bytes) send_random_write();
        send_item(KindStop, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("tb: %0d items accepted, %0d line states compared", items_seen, results_seen);
    $display("tb: covered every kind, lane byte extremes, random stalls and a long output hold");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
